// File: hw/rtl/tagged_geometric_branch_predictor_macros.svh
// Assertion macros for the tagged geometric branch predictor
`ifndef TAGGED_GEOMETRIC_BRANCH_PREDICTOR_MACROS_SVH
`define TAGGED_GEOMETRIC_BRANCH_PREDICTOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TGBP_ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define TGBP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TGBP_ASSERT_IMPL(label, clk, rstn, prop, msg)
`define TGBP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: hw/rtl/tgbp_pkg.sv
// Shared types and constants of the tagged geometric branch predictor
package tgbp_pkg;
    localparam int NumTables = 4;
    localparam logic [2:0] BaseProvider = 3'd4;
    localparam logic ActPredict = 1'b0;
    localparam logic ActUpdate = 1'b1;
    localparam int TagBits = 8;
    localparam int CtrBits = 3;
    localparam int UsefulBits = 2;
    localparam logic signed [2:0] CtrMax = 3'sd3;
    localparam logic signed [2:0] CtrMin = -3'sd4;
    localparam logic [1:0] UsefulMax = 2'd3;

    typedef struct packed {
        logic [TagBits-1:0] tag;
        logic signed [CtrBits-1:0] ctr;
        logic [UsefulBits-1:0] useful;
    } entry_t;

    function automatic logic [11:0] fold12(input logic [63:0] h);
        logic [71:0] x;
        logic [11:0] acc;
        x = {8'd0, h};
        acc = '0;
        for (int c = 0; c < 6; c++) acc ^= x[c*12 +: 12];
        return acc;
    endfunction

    function automatic logic [7:0] fold8(input logic [63:0] h);
        logic [7:0] acc;
        acc = '0;
        for (int c = 0; c < 8; c++) acc ^= h[c*8 +: 8];
        return acc;
    endfunction

    function automatic logic [6:0] fold7(input logic [63:0] h);
        logic [69:0] x;
        logic [6:0] acc;
        x = {6'd0, h};
        acc = '0;
        for (int c = 0; c < 10; c++) acc ^= x[c*7 +: 7];
        return acc;
    endfunction
endpackage

// File: hw/rtl/tgbp_table.sv
// One tagged table: synchronous memory with one read and one write port
module tgbp_table #(
    parameter int ENTRIES = 4096,
    parameter int IW = 12
) (
    input  logic               aclk,
    input  logic [IW-1:0]      rd_addr,
    output tgbp_pkg::entry_t   rd_data,
    input  logic               wr_en,
    input  logic [IW-1:0]      wr_addr,
    input  tgbp_pkg::entry_t   wr_data
);
    tgbp_pkg::entry_t mem [ENTRIES];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

// File: hw/rtl/tagged_geometric_branch_predictor.sv
// Top level of the tagged geometric branch predictor
//   channel | ports                                         | direction
//   s_      | action pc base_taken outcome was_predicted    | in
//           | provider                                      |
//   m_      | prediction provider_table                     | out
// After reset a clearing pass writes all TABLE_ENTRIES rows, one row of all four
// tables a cycle, with s_ready low. Each item is then handled in order: read the
// four table rows, then decide and write back. A predict's result waits in an
// output register; the next item is taken only after the write back, and only
// when that register is free or drains in the same cycle, so a stalled m_ready stalls s_ready.
`include "tagged_geometric_branch_predictor_macros.svh"
module tagged_geometric_branch_predictor #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int HISTORY_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [31:0] s_pc,
    input  logic        s_base_taken,
    input  logic        s_outcome,
    input  logic        s_was_predicted,
    input  logic [2:0]  s_provider,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_prediction,
    output logic [2:0]  m_provider_table
);
    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int NT = tgbp_pkg::NumTables;
    localparam logic [1:0] ST_CLEAR = 2'd0, ST_IDLE = 2'd1, ST_EVAL = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [IW:0] clr_reg;
    logic [HISTORY_BITS-1:0] hist_reg;
    logic act_reg, base_reg, out_reg, pred_reg;
    logic [2:0] prov_reg;
    logic [IW-1:0] idx_reg [NT];
    logic [7:0] tag_reg [NT];
    logic mv_reg, mp_reg;
    logic [2:0] mt_reg;

    logic [IW-1:0] idx_c [NT];
    logic [7:0] tag_c [NT];
    tgbp_pkg::entry_t rd [NT];
    tgbp_pkg::entry_t wd [NT];
    logic [NT-1:0] we;
    logic [IW-1:0] wa [NT];
    logic [NT-1:0] hit;
    logic res_dir;
    logic [2:0] res_tab;

    assign s_ready = (state_reg == ST_IDLE) && (!mv_reg || m_ready);
    assign m_valid = mv_reg;
    assign m_prediction = mp_reg;
    assign m_provider_table = mt_reg;

    always_comb begin
        logic [63:0] h;
        logic [11:0] f12;
        logic [7:0] f8;
        logic [6:0] f7;
        logic [31:0] v;
        for (int s = 0; s < NT; s++) begin
            h = 64'(hist_reg);
            case (s)
                0: h = h;
                1: h = h & 64'h7FFFFFF;
                2: h = h & 64'hFFF;
                default: h = h & 64'h1F;
            endcase
            f12 = tgbp_pkg::fold12(h);
            f8 = tgbp_pkg::fold8(h);
            f7 = tgbp_pkg::fold7(h);
            v = s_pc ^ (s_pc >> 4) ^ {20'd0, f12};
            idx_c[s] = v[IW-1:0];
            tag_c[s] = s_pc[7:0] ^ f8 ^ {f7, 1'b0};
        end
    end

    genvar g;
    for (g = 0; g < NT; g++) begin : g_tab
        tgbp_table #(.ENTRIES(TABLE_ENTRIES), .IW(IW)) u_tab (
            .aclk(aclk), .rd_addr(idx_c[g]), .rd_data(rd[g]),
            .wr_en(we[g]), .wr_addr(wa[g]), .wr_data(wd[g]));
        assign hit[g] = rd[g].tag == tag_reg[g];
    end

    always_comb begin
        logic found, alt;
        logic [2:0] p;
        logic mis, placed;
        tgbp_pkg::entry_t e;
        found = 1'b0;
        alt = base_reg;
        e = '0;
        res_dir = base_reg;
        res_tab = tgbp_pkg::BaseProvider;
        for (int s = NT - 1; s >= 0; s--) begin
            if (hit[s]) begin
                alt = base_reg;
                for (int a = NT - 1; a > s; a--) begin
                    if (hit[a]) alt = rd[a].ctr > 0;
                end
                res_tab = 3'(s);
                if (rd[s].ctr >= -3'sd1 && rd[s].ctr <= 3'sd1 && rd[s].useful == 2'd0)
                    res_dir = alt;
                else
                    res_dir = rd[s].ctr > 0;
                found = 1'b1;
            end
        end
        p = (prov_reg > tgbp_pkg::BaseProvider) ? tgbp_pkg::BaseProvider : prov_reg;
        mis = out_reg != pred_reg;
        placed = 1'b0;
        for (int s = 0; s < NT; s++) begin
            wd[s] = rd[s];
            we[s] = 1'b0;
            wa[s] = idx_reg[s];
        end
        for (int s = 0; s < NT; s++) begin
            if (3'(s) == p) begin
                e = rd[s];
                if (out_reg) begin
                    if (e.ctr < tgbp_pkg::CtrMax) e.ctr = e.ctr + 3'sd1;
                end else if (e.ctr > tgbp_pkg::CtrMin) e.ctr = e.ctr - 3'sd1;
                if (mis) begin
                    if (e.useful > 2'd0) e.useful = e.useful - 2'd1;
                end else if (e.useful < tgbp_pkg::UsefulMax) e.useful = e.useful + 2'd1;
                wd[s] = e;
                we[s] = 1'b1;
            end
        end
        if (mis) begin
            for (int s = NT - 1; s >= 0; s--) begin
                if (3'(s) < p && !placed && rd[s].useful == 2'd0) begin
                    wd[s].tag = tag_reg[s];
                    wd[s].ctr = out_reg ? 3'sd1 : -3'sd1;
                    wd[s].useful = 2'd0;
                    we[s] = 1'b1;
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                for (int s = 0; s < NT; s++) begin
                    if (3'(s) < p) begin
                        if (rd[s].useful > 2'd0) wd[s].useful = rd[s].useful - 2'd1;
                        we[s] = 1'b1;
                    end
                end
            end
        end
        if (state_reg == ST_CLEAR) begin
            for (int s = 0; s < NT; s++) begin
                we[s] = 1'b1;
                wa[s] = clr_reg[IW-1:0];
                wd[s] = '0;
            end
        end else if (!(state_reg == ST_EVAL && act_reg == tgbp_pkg::ActUpdate)) begin
            we = '0;
        end
        if (!found) res_tab = tgbp_pkg::BaseProvider;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == (IW+1)'(TABLE_ENTRIES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid && s_ready) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            hist_reg <= '0;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (mv_reg && m_ready) mv_reg <= 1'b0;
            if (state_reg == ST_EVAL) begin
                if (act_reg == tgbp_pkg::ActPredict) begin
                    mv_reg <= 1'b1;
                    mp_reg <= res_dir;
                    mt_reg <= res_tab;
                end else begin
                    hist_reg <= {hist_reg[HISTORY_BITS-2:0], out_reg};
                end
            end
        end
        if (s_valid && s_ready) begin
            act_reg <= s_action;
            base_reg <= s_base_taken;
            out_reg <= s_outcome;
            pred_reg <= s_was_predicted;
            prov_reg <= s_provider;
            for (int s = 0; s < NT; s++) begin
                idx_reg[s] <= idx_c[s];
                tag_reg[s] <= tag_c[s];
            end
        end
    end

    `TGBP_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, (state_reg != ST_IDLE) |-> !s_ready, "ready while busy")
    `TGBP_ASSERT_IMPL(a_eval_follows, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_EVAL), "no eval after accept")
    `TGBP_ASSERT_IMPL(a_tab_range, aclk, aresetn, m_valid |-> (m_provider_table <= tgbp_pkg::BaseProvider), "bad provider")
    `TGBP_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (state_reg == ST_CLEAR), "reset not clearing")
endmodule

// File: bench/tagged_geometric_branch_predictor_tb.sv
// Self-checking testbench of the tagged geometric branch predictor
module tagged_geometric_branch_predictor_tb;
    localparam int Entries = 4096;
    localparam int WatchdogLimit = 40000;
    localparam int HoldCycles = 300;
    localparam int HistLen [4] = '{64, 27, 12, 5};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_action = tgbp_pkg::ActPredict;
    logic [31:0] s_pc = '0;
    logic        s_base_taken = 1'b0;
    logic        s_outcome = 1'b0;
    logic        s_was_predicted = 1'b0;
    logic [2:0]  s_provider = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_prediction;
    logic [2:0]  m_provider_table;

    typedef struct packed {
        logic       taken;
        logic [2:0] table_id;
    } guess_t;

    logic [63:0]                         hist;
    logic [tgbp_pkg::TagBits-1:0]        tags    [4*Entries];
    logic signed [tgbp_pkg::CtrBits-1:0] conf    [4*Entries];
    logic [tgbp_pkg::UsefulBits-1:0]     useful  [4*Entries];
    guess_t                              guesses [$];

    int  errors = 0;
    int  idle_cycles = 0;
    int  hold_count = 0;
    int  predicts = 0;
    int  updates = 0;
    bit  hold_off = 1'b0;
    bit  sending_done = 1'b0;

    tagged_geometric_branch_predictor u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [63:0] hist_fold(int s, int width);
        logic [63:0] h;
        logic [63:0] acc;
        h = (HistLen[s] >= 64) ? hist : (hist & ((64'd1 << HistLen[s]) - 1));
        acc = '0;
        while (h != 0) begin
            acc ^= h & ((64'd1 << width) - 1);
            h >>= width;
        end
        return acc;
    endfunction

    function automatic int slot(logic [31:0] pc, int s);
        logic [63:0] v;
        v = {32'd0, pc ^ (pc >> 4)} ^ hist_fold(s, 12);
        return s * Entries + int'(v % Entries);
    endfunction

    function automatic logic [7:0] tag_hash(logic [31:0] pc, int s);
        logic [63:0] v;
        v = {32'd0, pc} ^ hist_fold(s, 8) ^ (hist_fold(s, 7) << 1);
        return v[7:0];
    endfunction

    function automatic bit hit(logic [31:0] pc, int s);
        return tags[slot(pc, s)] == tag_hash(pc, s);
    endfunction

    function automatic guess_t predict_direction(logic [31:0] pc, logic base);
        guess_t g;
        int i;
        g.taken = base;
        g.table_id = tgbp_pkg::BaseProvider;
        for (int s = 0; s < tgbp_pkg::NumTables; s++) begin
            if (hit(pc, s)) begin
                i = slot(pc, s);
                g.table_id = 3'(s);
                if (conf[i] >= -1 && conf[i] <= 1 && useful[i] == 0) begin
                    g.taken = base;
                    for (int a = s + 1; a < tgbp_pkg::NumTables; a++) begin
                        if (hit(pc, a)) begin
                            g.taken = conf[slot(pc, a)] > 0;
                            break;
                        end
                    end
                end else begin
                    g.taken = conf[i] > 0;
                end
                return g;
            end
        end
        return g;
    endfunction

    task automatic train(logic [31:0] pc, logic taken, logic pred, logic [2:0] prov_in);
        int prov;
        int i;
        bit placed;
        prov = (prov_in > tgbp_pkg::BaseProvider) ? tgbp_pkg::NumTables : int'(prov_in);
        placed = 1'b0;
        if (prov < tgbp_pkg::NumTables) begin
            i = slot(pc, prov);
            if (taken) begin
                if (conf[i] < tgbp_pkg::CtrMax) conf[i] = conf[i] + 1;
            end else if (conf[i] > tgbp_pkg::CtrMin) begin
                conf[i] = conf[i] - 1;
            end
            if (taken != pred) begin
                if (useful[i] > 0) useful[i] = useful[i] - 1;
            end else if (useful[i] < tgbp_pkg::UsefulMax) begin
                useful[i] = useful[i] + 1;
            end
        end
        if (taken != pred) begin
            for (int s = prov; s > 0 && !placed; s--) begin
                i = slot(pc, s - 1);
                if (useful[i] == 0) begin
                    tags[i] = tag_hash(pc, s - 1);
                    conf[i] = taken ? 3'sd1 : -3'sd1;
                    placed = 1'b1;
                end
            end
            if (!placed) begin
                for (int s = prov; s > 0; s--) begin
                    i = slot(pc, s - 1);
                    if (useful[i] > 0) useful[i] = useful[i] - 1;
                end
            end
        end
        hist = {hist[62:0], taken};
    endtask

    task automatic random_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0) n = 0;
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_word(logic act, logic [31:0] pc, logic base, logic taken,
                             logic pred, logic [2:0] prov);
        s_valid <= 1'b1;
        s_action <= act;
        s_pc <= pc;
        s_base_taken <= base;
        s_outcome <= taken;
        s_was_predicted <= pred;
        s_provider <= prov;
        do @(posedge aclk); while (!s_ready);
        if (act == tgbp_pkg::ActPredict) begin
            guesses.push_back(predict_direction(pc, base));
            predicts++;
        end else begin
            train(pc, taken, pred, prov);
            updates++;
        end
        if ($urandom_range(0, 1) == 0) random_gap();
    endtask

    task automatic send_branch(logic [31:0] pc);
        guess_t g;
        logic taken;
        g = predict_direction(pc, 1'($urandom));
        send_word(tgbp_pkg::ActPredict, pc, g.taken, 1'b0, 1'b0, '0);
        taken = ($urandom_range(0, 3) == 0) ? ~pc[2] : pc[2] ^ hist[0];
        send_word(tgbp_pkg::ActUpdate, pc, 1'($urandom), taken, g.taken, g.table_id);
    endtask

    task automatic test_directed();
        logic [31:0] corners [4] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0FF0};
        foreach (corners[k]) begin
            send_word(tgbp_pkg::ActPredict, corners[k], k[0], 1'b1, 1'b1, 3'd7);
        end
        for (int p = 0; p < 8; p++) begin
            send_word(tgbp_pkg::ActUpdate, corners[p % 4], 1'b1, p[0], ~p[0], 3'(p));
            send_word(tgbp_pkg::ActPredict, corners[p % 4], p[1], 1'b0, 1'b0, '0);
        end
        send_word(tgbp_pkg::ActUpdate, 32'h0, 1'b0, 1'b1, 1'b0, 3'd0);
        send_word(tgbp_pkg::ActUpdate, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 3'd3);
    endtask

    task automatic test_random_branches();
        logic [31:0] pcs [16];
        foreach (pcs[k]) pcs[k] = $urandom;
        for (int n = 0; n < 1400; ) begin
            if ($urandom_range(0, 4) == 0) begin
                send_word(1'($urandom), $urandom, 1'($urandom), 1'($urandom),
                          1'($urandom), 3'($urandom));
                n++;
            end else begin
                send_branch(pcs[$urandom_range(0, 15)]);
                n += 2;
            end
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int n = 0; n < 20; n++) begin
            send_word(tgbp_pkg::ActPredict, $urandom, 1'($urandom), 1'b0, 1'b0, '0);
        end
        hold_off = 1'b0;
        for (int n = 0; n < 400; n += 2) send_branch({20'd0, 12'($urandom)});
    endtask

    always @(posedge aclk) begin
        if (hold_off && hold_count < HoldCycles) begin
            m_ready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
        end
        if (aresetn && m_valid && m_ready) begin
            if (guesses.size() == 0) begin
                $error("unexpected prediction %0d from table %0d",
                       m_prediction, m_provider_table);
                errors++;
            end else begin
                guess_t g;
                g = guesses.pop_front();
                if (m_prediction !== g.taken) begin
                    $error("prediction: expected %0d, got %0d", g.taken, m_prediction);
                    errors++;
                end
                if (m_provider_table !== g.table_id) begin
                    $error("provider_table: expected %0d, got %0d",
                           g.table_id, m_provider_table);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WatchdogLimit) begin
            $display("tagged_geometric_branch_predictor_tb NOT OK");
            $finish;
        end
    end

    initial begin
        hist = '0;
        foreach (tags[k]) begin
            tags[k] = '0;
            conf[k] = '0;
            useful[k] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_branches();
        test_backpressure();
        s_valid <= 1'b0;
        while (guesses.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Covered %0d predicts and %0d updates, incl. a long output stall.",
                 predicts, updates);
        if (errors == 0 && guesses.size() == 0) begin
            $display("tagged_geometric_branch_predictor_tb OK");
        end else begin
            $display("tagged_geometric_branch_predictor_tb NOT OK");
        end
        $finish;
    end
endmodule
